// File: rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared constants, codes and handshake structs of the counting semaphore core.
// ----------------------------------------------------------------------------
package csem_pkg;

   localparam int MAX_WAITERS = 16;
   localparam int IDX_BITS    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_WAITERS + 1);
   localparam int TASK_BITS   = 8;
   localparam int CLOCK_BITS  = 32;
   localparam int COUNT_BITS  = 17;
   localparam int TIMEOUT_BITS = 16;
   localparam int INIT_BITS   = 16;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 17'sd65535;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [2:0] {
      MODE_WAIT   = 3'd0,
      MODE_TIMED  = 3'd1,
      MODE_TRY    = 3'd2,
      MODE_SIGNAL = 3'd3,
      MODE_TICK   = 3'd4,
      MODE_CLOSE  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_ACQUIRED    = 3'd0,
      ST_BLOCKED     = 3'd1,
      ST_WOULD_BLOCK = 3'd2,
      ST_TIMED_OUT   = 3'd3,
      ST_DEAD        = 3'd4,
      ST_NO_WAKE     = 3'd5,
      ST_QUEUE_FULL  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FETCH,
      S_ENTRY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_cfg;
      logic load_req;
      logic exec_decide;
      logic exec_entry;
      logic exec_finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic go_fetch;
      logic entry_last;
      logic is_tick;
   } stat_type;

   // circular queue index add, b below MAX_WAITERS
   function automatic idx_type idx_add(idx_type a, cnt_type b);
      logic [CNT_BITS:0] s;
      s = (CNT_BITS+1)'(a) + (CNT_BITS+1)'(b);
      if (s >= (CNT_BITS+1)'(MAX_WAITERS)) begin
         s = s - (CNT_BITS+1)'(MAX_WAITERS);
      end
      return s[IDX_BITS-1:0];
   endfunction

endpackage

// File: rtl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Sequencer: request intake, decision step, waiter queue walk, final result.
// ----------------------------------------------------------------------------
module csem_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              csr_valid,
   output logic              csr_ready,
   output csem_pkg::cmd_type cmd,
   input  csem_pkg::stat_type stat
);
   import csem_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            csr_ready    = 1'b1;
            cmd.load_cfg = csr_valid;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.out_free) begin
               cmd.exec_decide = 1'b1;
               state_in        = stat.go_fetch ? S_FETCH : S_IDLE;
            end
         end
         S_FETCH: begin
            state_in = S_ENTRY;
         end
         S_ENTRY: begin
            if (stat.out_free) begin
               cmd.exec_entry = 1'b1;
               if (stat.entry_last) begin
                  state_in = stat.is_tick ? S_FINISH : S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.exec_finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/csem_dpath.sv
// ----------------------------------------------------------------------------
// csem_dpath
// Permit count, tick clock, circular waiter queue and result register.
// ----------------------------------------------------------------------------
module csem_dpath (
   input  logic               clock,
   input  logic               reset,
   input  csem_pkg::cmd_type  cmd,
   output csem_pkg::stat_type stat,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_task,
   input  logic [15:0]        req_timeout,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_task,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);
   import csem_pkg::*;

   logic signed [COUNT_BITS-1:0] permit_ff, permit_in;
   logic                         closed_ff, closed_in;
   logic [CLOCK_BITS-1:0]        tick_ff, tick_in;
   idx_type                      head_ff, head_in;
   cnt_type                      total_ff, total_in;
   cnt_type                      rd_idx_ff, rd_idx_in;
   cnt_type                      wr_idx_ff, wr_idx_in;
   logic [2:0]                   mode_ff, mode_in;
   logic [TASK_BITS-1:0]         task_ff, task_in;
   logic [TIMEOUT_BITS-1:0]      timeout_ff, timeout_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [TASK_BITS-1:0]         pend_task_ff, pend_task_in;
   logic                         out_valid_ff, out_valid_in;
   logic [TASK_BITS-1:0]         out_task_ff, out_task_in;
   status_type                   out_status_ff, out_status_in;
   logic                         out_last_ff, out_last_in;

   logic [TASK_BITS-1:0]  waiter_task_ff  [MAX_WAITERS];
   logic                  waiter_timed_ff [MAX_WAITERS];
   logic [CLOCK_BITS-1:0] waiter_dl_ff    [MAX_WAITERS];
   logic [TASK_BITS-1:0]  rd_task_ff;
   logic                  rd_timed_ff;
   logic [CLOCK_BITS-1:0] rd_dl_ff;

   logic                  mem_we;
   idx_type               mem_waddr;
   idx_type               mem_raddr;
   logic [TASK_BITS-1:0]  mem_wtask;
   logic                  mem_wtimed;
   logic [CLOCK_BITS-1:0] mem_wdl;

   logic                  emit;
   logic [TASK_BITS-1:0]  emit_task;
   status_type            emit_status;
   logic                  emit_last;

   logic                  closed_op;
   logic                  has_waiters;
   logic                  expired;
   logic [CLOCK_BITS-1:0] diff;
   cnt_type               rd_next;
   cnt_type               wr_next;

   assign mem_raddr   = idx_add(head_ff, rd_idx_ff);
   assign has_waiters = (total_ff != '0);
   assign closed_op   = (mode_ff <= MODE_SIGNAL) && closed_ff;
   assign diff        = tick_ff - rd_dl_ff;
   assign expired     = rd_timed_ff && !diff[CLOCK_BITS-1];
   assign rd_next     = rd_idx_ff + cnt_type'(1);
   assign wr_next     = expired ? wr_idx_ff : wr_idx_ff + cnt_type'(1);

   assign stat.out_free   = !out_valid_ff || rsp_ready;
   assign stat.go_fetch   = !closed_op && has_waiters &&
                            ((mode_ff == MODE_SIGNAL) ||
                             (mode_ff == MODE_TICK && !closed_ff) ||
                             (mode_ff == MODE_CLOSE));
   assign stat.entry_last = (mode_ff == MODE_SIGNAL) || (rd_next == total_ff);
   assign stat.is_tick    = (mode_ff == MODE_TICK);

   assign rsp_valid  = out_valid_ff;
   assign rsp_task   = out_task_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

   always_comb begin
      permit_in     = permit_ff;
      closed_in     = closed_ff;
      tick_in       = tick_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      mode_in       = mode_ff;
      task_in       = task_ff;
      timeout_in    = timeout_ff;
      pend_valid_in = pend_valid_ff;
      pend_task_in  = pend_task_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_add(head_ff, total_ff);
      mem_wtask     = task_ff;
      mem_wtimed    = (mode_ff == MODE_TIMED);
      mem_wdl       = (mode_ff == MODE_TIMED) ?
                      tick_ff + CLOCK_BITS'(timeout_ff) : '0;
      emit          = 1'b0;
      emit_task     = task_ff;
      emit_status   = ST_NO_WAKE;
      emit_last     = 1'b1;

      if (cmd.load_cfg) begin
         permit_in = COUNT_BITS'(csr_data);
         closed_in = 1'b0;
         total_in  = '0;
         head_in   = '0;
      end

      if (cmd.load_req) begin
         mode_in    = req_mode;
         task_in    = req_task;
         timeout_in = req_timeout;
      end

      if (cmd.exec_decide) begin
         rd_idx_in     = '0;
         wr_idx_in     = '0;
         pend_valid_in = 1'b0;
         if (closed_op) begin
            emit        = 1'b1;
            emit_status = ST_DEAD;
         end else begin
            unique case (mode_ff)
               MODE_WAIT, MODE_TIMED, MODE_TRY: begin
                  emit = 1'b1;
                  if (permit_ff > 0) begin
                     permit_in   = permit_ff - COUNT_BITS'(1);
                     emit_status = ST_ACQUIRED;
                  end else if (mode_ff == MODE_TRY ||
                               (mode_ff == MODE_TIMED && timeout_ff == '0)) begin
                     emit_status = ST_WOULD_BLOCK;
                  end else if (total_ff >= cnt_type'(MAX_WAITERS)) begin
                     emit_status = ST_QUEUE_FULL;
                  end else begin
                     permit_in   = permit_ff - COUNT_BITS'(1);
                     mem_we      = 1'b1;
                     total_in    = total_ff + cnt_type'(1);
                     emit_status = ST_BLOCKED;
                  end
               end
               MODE_SIGNAL: begin
                  if (!has_waiters) begin
                     if (permit_ff < COUNT_MAX) begin
                        permit_in = permit_ff + COUNT_BITS'(1);
                     end
                     emit = 1'b1;
                  end
               end
               MODE_TICK: begin
                  tick_in = tick_ff + CLOCK_BITS'(1);
                  emit    = !(has_waiters && !closed_ff);
               end
               MODE_CLOSE: begin
                  closed_in = 1'b1;
                  emit      = !has_waiters;
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
      end

      if (cmd.exec_entry) begin
         rd_idx_in = rd_next;
         unique case (mode_ff)
            MODE_SIGNAL: begin
               permit_in   = permit_ff + COUNT_BITS'(1);
               head_in     = idx_add(head_ff, cnt_type'(1));
               total_in    = total_ff - cnt_type'(1);
               emit        = 1'b1;
               emit_task   = rd_task_ff;
               emit_status = ST_ACQUIRED;
            end
            MODE_CLOSE: begin
               emit        = 1'b1;
               emit_task   = rd_task_ff;
               emit_status = ST_DEAD;
               emit_last   = stat.entry_last;
               if (stat.entry_last) begin
                  total_in = '0;
                  head_in  = '0;
               end
            end
            default: begin
               wr_idx_in = wr_next;
               if (expired) begin
                  permit_in     = permit_ff + COUNT_BITS'(1);
                  emit          = pend_valid_ff;
                  emit_task     = pend_task_ff;
                  emit_status   = ST_TIMED_OUT;
                  emit_last     = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_task_in  = rd_task_ff;
               end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = idx_add(head_ff, wr_idx_ff);
                  mem_wtask  = rd_task_ff;
                  mem_wtimed = rd_timed_ff;
                  mem_wdl    = rd_dl_ff;
               end
               if (stat.entry_last) begin
                  total_in = wr_next;
               end
            end
         endcase
      end

      if (cmd.exec_finish) begin
         emit = 1'b1;
         if (pend_valid_ff) begin
            emit_task   = pend_task_ff;
            emit_status = ST_TIMED_OUT;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_task_in   = out_task_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_task_in   = emit_task;
         out_status_in = emit_status;
         out_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         permit_ff     <= '0;
         closed_ff     <= 1'b0;
         tick_ff       <= '0;
         head_ff       <= '0;
         total_ff      <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         permit_ff     <= permit_in;
         closed_ff     <= closed_in;
         tick_ff       <= tick_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      mode_ff       <= mode_in;
      task_ff       <= task_in;
      timeout_ff    <= timeout_in;
      pend_task_ff  <= pend_task_in;
      out_task_ff   <= out_task_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         waiter_task_ff[mem_waddr]  <= mem_wtask;
         waiter_timed_ff[mem_waddr] <= mem_wtimed;
         waiter_dl_ff[mem_waddr]    <= mem_wdl;
      end
      rd_task_ff  <= waiter_task_ff[mem_raddr];
      rd_timed_ff <= waiter_timed_ff[mem_raddr];
      rd_dl_ff    <= waiter_dl_ff[mem_raddr];
   end

endmodule

// File: rtl/counting_semaphore_timed_wait_core.sv
// Sequence: the decision step registers the result; a signal with a waiter goes on
// to fetch and entry. Tick and close walk the waiter queue with a fetch and an
// entry step per entry (queue read), tick adds one final step.
// Decide/entry/finish stall on a held result; next request taken in idle only.
// Reset: count, closed flag, tick clock and queue fill cleared; queue memory is
// not cleared, entries past the fill are never read.
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait_core
// Counting semaphore with a FIFO of blocked tasks, timed waits and close.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] task_id, [23:8] timeout
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] task_ref, [10:8] status, [15:11] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import csem_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] rsp_task;
   logic [2:0] rsp_status;

   csem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   csem_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req_tuser),
      .req_task    (req_tdata[7:0]),
      .req_timeout (req_tdata[23:8]),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_task    (rsp_task),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_status, rsp_task};

endmodule

// File: tb/semaphore_checker.sv
// ----------------------------------------------------------------------------
// semaphore_checker
// Watches the request, result and register channels of the semaphore core,
// keeps its own copy of the permit count, waiter queue, tick clock and closed
// flag, works out the results each request transfer must cause and compares
// every result transfer with the oldest one still owed.
// ----------------------------------------------------------------------------
module semaphore_checker
   import csem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] task_id, [23:8] timeout
   input  logic [2:0]  req_tuser,   // [2:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] task_ref, [10:8] status, [15:11] zero
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          mismatches,
   output int          notices_owed
);

   localparam int WAKE_LIMIT = 16;

   typedef struct {
      logic [TASK_BITS-1:0] who;
      logic [2:0]           status;
      logic                 last;
   } notice_t;

   typedef struct {
      logic [TASK_BITS-1:0]  who;
      logic                  timed;
      logic [CLOCK_BITS-1:0] deadline;
   } waiter_t;

   notice_t                        owed[$];
   notice_t                        batch[$];
   waiter_t                        waiters[$];
   logic signed [COUNT_BITS-1:0]   permits;
   logic                           sem_closed;
   logic [CLOCK_BITS-1:0]          tick_now;
   int                             error_total;

   task post(input logic [TASK_BITS-1:0] who, input status_type st);
      if (batch.size() < WAKE_LIMIT) begin
         batch.push_back('{who, st, 1'b0});
      end
   endtask

   task try_take(input logic [TASK_BITS-1:0] who);
      if (permits > 0) begin
         permits = permits - 1;
         post(who, ST_ACQUIRED);
      end else begin
         post(who, ST_WOULD_BLOCK);
      end
   endtask

   task take_or_block(input logic [TASK_BITS-1:0] who, input logic timed,
                      input logic [TIMEOUT_BITS-1:0] ticks);
      waiter_t w;
      if (permits > 0) begin
         permits = permits - 1;
         post(who, ST_ACQUIRED);
      end else if (waiters.size() >= MAX_WAITERS) begin
         post(who, ST_QUEUE_FULL);
      end else begin
         permits = permits - 1;
         w.who = who;
         w.timed = timed;
         w.deadline = timed ? tick_now + CLOCK_BITS'(ticks) : '0;
         waiters.push_back(w);
         post(who, ST_BLOCKED);
      end
   endtask

   task predict_request(input logic [2:0] op, input logic [TASK_BITS-1:0] who,
                        input logic [TIMEOUT_BITS-1:0] ticks);
      int                    i;
      logic [CLOCK_BITS-1:0] age;
      logic [TASK_BITS-1:0]  woken;
      batch.delete();
      if (op <= MODE_SIGNAL && sem_closed) begin
         post(who, ST_DEAD);
      end else begin
         case (op)
            MODE_WAIT: take_or_block(who, 1'b0, ticks);
            MODE_TIMED: begin
               if (ticks == 0) try_take(who);
               else take_or_block(who, 1'b1, ticks);
            end
            MODE_TRY: try_take(who);
            MODE_SIGNAL: begin
               if (waiters.size() > 0) begin
                  woken = waiters[0].who;
                  permits = permits + 1;
                  waiters.delete(0);
                  post(woken, ST_ACQUIRED);
               end else begin
                  if (permits < COUNT_MAX) permits = permits + 1;
                  post(who, ST_NO_WAKE);
               end
            end
            MODE_TICK: begin
               tick_now = tick_now + 1;
               if (!sem_closed) begin
                  i = 0;
                  while (i < waiters.size() && batch.size() < WAKE_LIMIT) begin
                     age = tick_now - waiters[i].deadline;
                     // wrap-safe: expired when the difference is not negative
                     if (waiters[i].timed && !age[CLOCK_BITS-1]) begin
                        woken = waiters[i].who;
                        waiters.delete(i);
                        permits = permits + 1;
                        post(woken, ST_TIMED_OUT);
                     end else begin
                        i++;
                     end
                  end
               end
               if (batch.size() == 0) post(who, ST_NO_WAKE);
            end
            MODE_CLOSE: begin
               sem_closed = 1'b1;
               while (waiters.size() > 0 && batch.size() < WAKE_LIMIT) begin
                  woken = waiters[0].who;
                  waiters.delete(0);
                  post(woken, ST_DEAD);
               end
               if (batch.size() == 0) post(who, ST_NO_WAKE);
            end
            default: post(who, ST_NO_WAKE);
         endcase
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) owed.push_back(batch[k]);
   endtask

   always @(posedge clock) begin : watch
      notice_t got;
      notice_t want;
      if (reset) begin
         permits = '0;
         sem_closed = 1'b0;
         tick_now = '0;
         waiters.delete();
         owed.delete();
      end else begin
         // results first: one finishing now cannot belong to a request taken now
         if (rsp_tvalid && rsp_tready) begin
            got.who = rsp_tdata[7:0];
            got.status = rsp_tdata[10:8];
            got.last = rsp_tlast;
            if (owed.size() == 0) begin
               error_total++;
               $display("%0t: unexpected result, got task %0d status %0d last %0d",
                        $time, got.who, got.status, got.last);
            end else begin
               want = owed.pop_front();
               if (got.who !== want.who || got.status !== want.status ||
                   got.last !== want.last) begin
                  error_total++;
                  $display("%0t: result mismatch, expected task %0d status %0d last %0d, got task %0d status %0d last %0d",
                           $time, want.who, want.status, want.last,
                           got.who, got.status, got.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            permits = COUNT_BITS'(csr_data);
            sem_closed = 1'b0;
            waiters.delete();
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata[7:0], req_tdata[23:8]);
         end
      end
      mismatches <= error_total;
      notices_owed <= owed.size();
   end

endmodule

// File: tb/counting_semaphore_timed_wait_core_tb.sv
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait_core_tb
// Drives directed and random semaphore requests and register writes into the
// core with random gaps and result back-pressure; a checker beside the core
// predicts and compares every result, this top gives the verdict.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait_core_tb;
   import csem_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RX_HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   int mismatches;
   int notices_owed;
   int tx_run_left;
   int rx_wait;
   int rx_free;
   bit rx_hold_req;
   bit rx_hold_done;

   counting_semaphore_timed_wait_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   semaphore_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .notices_owed (notices_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // result side back-pressure
   initial begin
      rsp_tready = 1'b0;
      rx_wait = 0;
      rx_free = 0;
      rx_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req && !rx_hold_done) begin
            rx_wait = RX_HOLD_CYCLES;
            rx_hold_done = 1'b1;
         end
         if (rx_wait > 0) begin
            rsp_tready <= 1'b0;
            rx_wait--;
         end else if (rx_free > 0) begin
            rsp_tready <= 1'b1;
            rx_free--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0) rx_free = $urandom_range(20, 80);
            else rx_wait = gap_len();
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_req(input logic [2:0] op, input logic [7:0] who,
                           input logic [15:0] ticks);
      int gap;
      if (tx_run_left > 0) begin
         gap = 0;
         tx_run_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         tx_run_left = $urandom_range(10, 30);
      end else begin
         gap = gap_len();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {ticks, who};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (notices_owed != 0);
   endtask

   task automatic reopen(input logic [15:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int          pick;
      logic [2:0]  op;
      logic [15:0] ticks;
      pick = $urandom_range(0, 99);
      if (pick < 24) op = MODE_WAIT;
      else if (pick < 50) op = MODE_TIMED;
      else if (pick < 60) op = MODE_TRY;
      else if (pick < 80) op = MODE_SIGNAL;
      else if (pick < 96) op = MODE_TICK;
      else if (pick < 97) op = MODE_CLOSE;
      else op = 3'($urandom_range(6, 7));
      case ($urandom_range(0, 9))
         0:       ticks = '0;
         1, 2:    ticks = 16'($urandom);
         default: ticks = 16'($urandom_range(1, 6));
      endcase
      send_req(op, 8'($urandom), ticks);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rx_hold_req = 1'b0;
      tx_run_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no permits after reset
      send_req(MODE_TRY,    8'h00, 16'h0000);
      send_req(MODE_TIMED,  8'hFF, 16'h0000);
      send_req(MODE_WAIT,   8'h01, 16'h0000);
      send_req(MODE_TIMED,  8'h02, 16'h0001);
      send_req(MODE_TIMED,  8'h03, 16'hFFFF);
      send_req(MODE_SIGNAL, 8'h09, 16'h0000);
      send_req(MODE_TICK,   8'h0A, 16'h0000);
      send_req(MODE_SIGNAL, 8'h0B, 16'h0000);
      send_req(MODE_SIGNAL, 8'h0C, 16'h0000);
      send_req(MODE_TIMED,  8'hAA, 16'h0005);
      send_req(3'd6,        8'h55, 16'h0000);
      send_req(3'd7,        8'hAA, 16'hFFFF);
      send_req(MODE_TICK,   8'h0D, 16'h0000);
      // fill the waiter queue, overflow it, then time all of them out at once
      for (int n = 0; n < MAX_WAITERS; n++) begin
         send_req(MODE_TIMED, 8'(8'h10 + n), 16'h0001);
      end
      send_req(MODE_WAIT,   8'hEE, 16'h0000);
      send_req(MODE_TICK,   8'h0E, 16'h0000);
      // close with waiters, then requests on a closed semaphore
      send_req(MODE_WAIT,   8'h20, 16'h0000);
      send_req(MODE_TIMED,  8'h21, 16'h0003);
      send_req(MODE_CLOSE,  8'h22, 16'h0000);
      send_req(MODE_WAIT,   8'h23, 16'h0000);
      send_req(MODE_SIGNAL, 8'h24, 16'h0000);
      send_req(MODE_TICK,   8'h25, 16'h0000);
      send_req(MODE_CLOSE,  8'h26, 16'h0000);

      // full count: signal saturates
      reopen(16'hFFFF);
      send_req(MODE_SIGNAL, 8'h30, 16'h0000);
      send_req(MODE_WAIT,   8'h31, 16'h0000);

      // results held off while requests keep coming
      rx_hold_req = 1'b1;
      repeat (50) send_random();

      reopen(16'h0000);
      repeat (50) send_random();
      reopen(16'($urandom_range(1, 3)));
      repeat (45) send_random();
      reopen(16'($urandom_range(0, 2)));
      repeat (45) send_random();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
